/* sv/assert_macros.svh */
// Assertion macros shared by the RTL. They expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* sv/fcd_pkg.sv */
package fcd_pkg;

	localparam int VCOUNT_W = 7;
	localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd49;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_VERTEX_COUNT = 1'b0;

	localparam logic ACT_EDGE = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WR_A,
		ST_RD_B,
		ST_WR_B,
		ST_PICK,
		ST_EXPAND,
		ST_DONE
	} fcd_state_t;

endpackage

/* sv/fcd_adj_mem.sv */
module fcd_adj_mem #(
	parameter int DEPTH = 64,
	parameter int AW = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [DEPTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [DEPTH-1:0] rdata
);

	logic [DEPTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] row_valid_q;
	logic [DEPTH-1:0] rd_data_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[raddr];
	end

	// A row that was never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (we) begin
				row_valid_q[waddr] <= 1'b1;
			end
			rd_valid_q <= row_valid_q[raddr];
		end
	end

	assign rdata = rd_valid_q ? rd_data_q : '0;

endmodule

/* sv/five_clique_detector.sv */
// Five-clique detector.
// The input channel (in_valid, in_ready, action, vertex_a, vertex_b) takes one
// item per transfer. An edge item sets both symmetric bits of the adjacency
// matrix and gives no result; it occupies the block while each of its two row
// updates is done as a read and then a write of the adjacency memory.
// A search item gives one transfer on the output channel (out_valid, out_ready,
// clique_found). The search backtracks over candidate masks kept in a small
// stack, one mask per depth. Each vertex tried below the last depth takes a
// pick step (pick the lowest candidate and read its row) and an expand step
// (intersect); each exhausted depth takes one pick step, as does the vertex
// that completes a clique, and a done step then gives the result.
// in_ready is high only while no item is in progress. The result register is
// separate, so the next item is taken while a result still waits.
// If the receiver stalls, a finished search waits with its answer until the
// result register is free. Reset clears the valid flag of every adjacency row
// at once, so the matrix reads as empty right away; vertex_count returns to 49.
// vertex_count is written over the APB port at byte address 0.
`include "assert_macros.svh"

module five_clique_detector #(
	parameter int MAX_VERTICES = 64,
	parameter int CLIQUE_SIZE = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fcd_pkg::PADDR_W-1:0]   paddr,
	input  logic [fcd_pkg::PDATA_W-1:0]   pwdata,
	output logic [fcd_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [5:0]                    vertex_a,
	input  logic [5:0]                    vertex_b,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          clique_found
);

	localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int DW = $clog2(CLIQUE_SIZE);
	localparam logic [DW-1:0] LAST_DEPTH = DW'(CLIQUE_SIZE - 1);
	localparam logic [6:0] MAXV = 7'(MAX_VERTICES);

	fcd_pkg::fcd_state_t state_q, state_d;

	logic [fcd_pkg::VCOUNT_W-1:0] vcount_q;
	logic [AW-1:0]                va_q, vb_q;
	logic [DW-1:0]                depth_q;
	logic [MAX_VERTICES-1:0]      stack_q [CLIQUE_SIZE];
	logic [MAX_VERTICES-1:0]      lowbit_q;
	logic                         found_q;
	logic                         out_valid_q;
	logic                         clique_found_q;

	logic                         in_xfer, edge_ok, out_free;
	logic                         mem_we;
	logic [AW-1:0]                mem_waddr, mem_raddr;
	logic [MAX_VERTICES-1:0]      mem_wdata, mem_rdata;
	logic [MAX_VERTICES-1:0]      cand, cand_iso, used_mask;
	logic [AW-1:0]                cand_idx;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == fcd_pkg::REG_VERTEX_COUNT) ?
		fcd_pkg::PDATA_W'(vcount_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= fcd_pkg::VCOUNT_RESET;
		end else if (psel && penable && pwrite && paddr[2] == fcd_pkg::REG_VERTEX_COUNT) begin
			vcount_q <= pwdata[fcd_pkg::VCOUNT_W-1:0];
		end
	end

	assign in_xfer = in_valid && in_ready;
	assign edge_ok = ({1'b0, vertex_a} < MAXV) && ({1'b0, vertex_b} < MAXV);
	assign out_free = !out_valid_q || out_ready;

	assign cand = stack_q[depth_q];
	assign cand_iso = cand & (~cand + MAX_VERTICES'(1));

	always_comb begin
		cand_idx = '0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			if (cand_iso[i]) begin
				cand_idx = cand_idx | AW'(i);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			used_mask[i] = 7'(i) < vcount_q;
		end
	end

	fcd_adj_mem #(
		.DEPTH(MAX_VERTICES),
		.AW(AW)
	) u_adj_mem (
		.clk(clk),
		.arst_n(arst_n),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		mem_we = 1'b0;
		mem_waddr = va_q;
		mem_wdata = mem_rdata | (MAX_VERTICES'(1) << vb_q);
		mem_raddr = vertex_a[AW-1:0];
		unique case (state_q)
			fcd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_xfer) begin
					if (action == fcd_pkg::ACT_SEARCH) begin
						state_d = fcd_pkg::ST_PICK;
					end else if (edge_ok) begin
						state_d = fcd_pkg::ST_WR_A;
					end
				end
			end
			fcd_pkg::ST_WR_A: begin
				mem_we = 1'b1;
				state_d = fcd_pkg::ST_RD_B;
			end
			fcd_pkg::ST_RD_B: begin
				mem_raddr = vb_q;
				state_d = fcd_pkg::ST_WR_B;
			end
			fcd_pkg::ST_WR_B: begin
				mem_we = 1'b1;
				mem_waddr = vb_q;
				mem_wdata = mem_rdata | (MAX_VERTICES'(1) << va_q);
				state_d = fcd_pkg::ST_IDLE;
			end
			fcd_pkg::ST_PICK: begin
				mem_raddr = cand_idx;
				if (cand == '0) begin
					if (depth_q == '0) begin
						state_d = fcd_pkg::ST_DONE;
					end
				end else if (depth_q == LAST_DEPTH) begin
					state_d = fcd_pkg::ST_DONE;
				end else begin
					state_d = fcd_pkg::ST_EXPAND;
				end
			end
			fcd_pkg::ST_EXPAND: begin
				state_d = fcd_pkg::ST_PICK;
			end
			fcd_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = fcd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fcd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fcd_pkg::ST_IDLE: begin
				va_q <= vertex_a[AW-1:0];
				vb_q <= vertex_b[AW-1:0];
				stack_q[0] <= used_mask;
			end
			fcd_pkg::ST_PICK: begin
				if (cand != '0) begin
					stack_q[depth_q] <= cand & (cand - MAX_VERTICES'(1));
					lowbit_q <= cand_iso;
				end
			end
			fcd_pkg::ST_EXPAND: begin
				stack_q[depth_q + DW'(1)] <= cand & mem_rdata & ~lowbit_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			found_q <= 1'b0;
			out_valid_q <= 1'b0;
			clique_found_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != fcd_pkg::ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				fcd_pkg::ST_IDLE: begin
					depth_q <= '0;
				end
				fcd_pkg::ST_PICK: begin
					if (cand == '0) begin
						if (depth_q == '0) begin
							found_q <= 1'b0;
						end else begin
							depth_q <= depth_q - DW'(1);
						end
					end else if (depth_q == LAST_DEPTH) begin
						found_q <= 1'b1;
					end
				end
				fcd_pkg::ST_EXPAND: begin
					depth_q <= depth_q + DW'(1);
				end
				fcd_pkg::ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						clique_found_q <= found_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign clique_found = clique_found_q;

	`ASSERT_NEXT(a_search_starts, clk, arst_n, in_xfer && action == fcd_pkg::ACT_SEARCH, state_q == fcd_pkg::ST_PICK, "accepted search did not start")
	`ASSERT_IMPLY(a_result_from_done, clk, arst_n, $rose(out_valid_q), $past(state_q) == fcd_pkg::ST_DONE, "result appeared outside the done step")
	`ASSERT_IMPLY(a_expand_after_pick, clk, arst_n, state_q == fcd_pkg::ST_EXPAND, $past(state_q) == fcd_pkg::ST_PICK && depth_q != LAST_DEPTH, "expand step out of order")
	`ASSERT_IMPLY(a_write_in_edge, clk, arst_n, mem_we, state_q == fcd_pkg::ST_WR_A || state_q == fcd_pkg::ST_WR_B, "adjacency write outside an edge load")

endmodule

/* bench/five_clique_detector_tb.sv */
`timescale 1ns / 1ps

module five_clique_detector_tb;

	localparam int MAX_VERTICES = 64;
	localparam int CLIQUE_SIZE = 5;
	localparam int REG_UNMAPPED = 1;
	localparam int RANDOM_ITEMS = 425;
	localparam int SETTLE_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 2000000;

	typedef struct packed {
		logic       action;
		logic [5:0] vertex_a;
		logic [5:0] vertex_b;
	} graph_item_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [fcd_pkg::PADDR_W-1:0]  paddr = '0;
	logic [fcd_pkg::PDATA_W-1:0]  pwdata = '0;
	logic [fcd_pkg::PDATA_W-1:0]  prdata;
	logic                         pready;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic                         action = fcd_pkg::ACT_EDGE;
	logic [5:0]                   vertex_a = '0;
	logic [5:0]                   vertex_b = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic                         clique_found;

	logic [63:0]                  adj_rows [MAX_VERTICES];
	logic [fcd_pkg::VCOUNT_W-1:0] vcount_shadow = fcd_pkg::VCOUNT_RESET;
	bit                           clique_answers [$];
	graph_item_t                  pending_items [$];
	graph_item_t                  next_item;

	bit                           in_taken = 1'b0;
	int                           gap_left = 0;
	int                           burst_left = 0;
	int                           ready_mode = 0;
	int                           mode_left = 0;
	int                           stall_cycle = 0;

	int                           queued_items = 0;
	int                           accepted_items = 0;
	int                           searches = 0;
	int                           found_count = 0;
	int                           empty_count = 0;
	int                           config_writes = 0;
	int                           mismatches = 0;
	int                           idle_cycles = 0;
	int                           random_left;
	int                           phase_items;
	int                           base;
	int                           top;
	int                           roll;
	int                           self_v;
	logic [fcd_pkg::VCOUNT_W-1:0] vc_pick;
	logic [31:0]                  wdata;

	five_clique_detector dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.vertex_a    (vertex_a),
		.vertex_b    (vertex_b),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.clique_found(clique_found)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			adj_rows[i] = '0;
		end
	end

	// Each stack level keeps the candidates still untried at that depth;
	// a level is dropped once too few remain to finish a clique.
	function automatic bit has_five_clique(logic [fcd_pkg::VCOUNT_W-1:0] vcount);
		logic [63:0] stack [CLIQUE_SIZE];
		int          n;
		int          d;
		int          v;

		n = (vcount > MAX_VERTICES) ? MAX_VERTICES : int'(vcount);
		stack[0] = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
		d = 0;
		while (d >= 0) begin
			if ($countones(stack[d]) < CLIQUE_SIZE - d) begin
				d--;
				continue;
			end
			v = 0;
			while (!stack[d][v]) begin
				v++;
			end
			stack[d] &= stack[d] - 64'd1;
			if (d + 1 == CLIQUE_SIZE) begin
				return 1'b1;
			end
			stack[d + 1] = stack[d] & adj_rows[v];
			d++;
		end
		return 1'b0;
	endfunction

	task automatic push_edge(input int a, input int b);
		pending_items.push_back({fcd_pkg::ACT_EDGE, 6'(a), 6'(b)});
		queued_items++;
	endtask

	task automatic push_search();
		graph_item_t pend;
		pend.action = fcd_pkg::ACT_SEARCH;
		pend.vertex_a = 6'($urandom_range(0, 63));
		pend.vertex_b = 6'($urandom_range(0, 63));
		pending_items.push_back(pend);
		queued_items++;
	endtask

	task automatic apb_write(input int idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= fcd_pkg::PADDR_W'(idx * 4);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		if (idx == fcd_pkg::REG_VERTEX_COUNT) begin
			vcount_shadow = value[fcd_pkg::VCOUNT_W-1:0];
		end
		config_writes++;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		while (accepted_items != queued_items || clique_answers.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				next_item = pending_items.pop_front();
				in_valid <= 1'b1;
				action <= next_item.action;
				vertex_a <= next_item.vertex_a;
				vertex_b <= next_item.vertex_b;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 15);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (mode_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(5, 60);
		end
		mode_left--;
		stall_cycle++;
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (stall_cycle % 4 == 0);
			default: out_ready <= (mode_left > 20);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			idle_cycles++;
			if (in_valid && in_ready) begin
				idle_cycles = 0;
				accepted_items++;
				if (action == fcd_pkg::ACT_EDGE) begin
					adj_rows[vertex_a][vertex_b] = 1'b1;
					adj_rows[vertex_b][vertex_a] = 1'b1;
				end else begin
					clique_answers.push_back(has_five_clique(vcount_shadow));
					searches++;
				end
			end
			if (out_valid && out_ready) begin
				idle_cycles = 0;
				if (clique_answers.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: unexpected result transfer, clique_found=%0b",
							$realtime, clique_found);
					end
				end else begin
					if (clique_answers[0]) begin
						found_count++;
					end else begin
						empty_count++;
					end
					if (clique_found !== clique_answers[0]) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: clique_found expected %0b, got %0b",
								$realtime, clique_answers[0], clique_found);
						end
					end
					void'(clique_answers.pop_front());
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("five_clique_detector: mismatch");
				$finish;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_search();
		for (int i = 0; i < 4; i++) begin
			for (int j = i + 1; j < 4; j++) begin
				push_edge(i, j);
			end
		end
		push_edge(0, 0);
		push_edge(3, 3);
		push_search();
		for (int i = 59; i < 64; i++) begin
			for (int j = i + 1; j < 64; j++) begin
				push_edge(j, i);
			end
		end
		push_search();
		drain();

		apb_write(fcd_pkg::REG_VERTEX_COUNT, 32'd64);
		push_search();
		drain();
		apb_write(fcd_pkg::REG_VERTEX_COUNT, 32'd127);
		push_search();
		drain();
		apb_write(REG_UNMAPPED, 32'd0);
		push_search();
		drain();
		apb_write(fcd_pkg::REG_VERTEX_COUNT, 32'd0);
		push_search();
		drain();

		random_left = RANDOM_ITEMS;
		while (random_left > 0) begin
			case ($urandom_range(0, 9))
				0: vc_pick = 7'd0;
				1: vc_pick = 7'd1;
				2: vc_pick = 7'd64;
				3: vc_pick = 7'($urandom_range(65, 127));
				4: vc_pick = 7'd5;
				default: vc_pick = 7'($urandom_range(2, 63));
			endcase
			wdata = {25'd0, vc_pick};
			if ($urandom_range(0, 1) == 1) begin
				wdata = ($urandom() & ~32'h7F) | wdata;
			end
			apb_write(fcd_pkg::REG_VERTEX_COUNT, wdata);

			// Most edges land in a narrow window of vertices so that dense
			// regions, and with them cliques, build up over the run.
			base = $urandom_range(0, 58);
			top = base + $urandom_range(4, 8);
			if (top > 63) begin
				top = 63;
			end
			phase_items = $urandom_range(20, 50);
			if (phase_items > random_left) begin
				phase_items = random_left;
			end
			for (int k = 0; k < phase_items; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 20) begin
					push_search();
				end else if (roll < 26) begin
					self_v = $urandom_range(0, 63);
					push_edge(self_v, self_v);
				end else if (roll < 36) begin
					push_edge($urandom_range(0, 63), $urandom_range(0, 63));
				end else begin
					push_edge($urandom_range(base, top), $urandom_range(base, top));
				end
			end
			random_left -= phase_items;
			drain();
		end

		$display("Sent %0d items, %0d of them searches, across %0d register writes.",
			accepted_items, searches, config_writes);
		$display("Searches that found a clique: %0d; searches that found none: %0d.",
			found_count, empty_count);
		if (mismatches == 0 && clique_answers.size() == 0) begin
			$display("five_clique_detector: match");
		end else begin
			$display("five_clique_detector: mismatch");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/fcd_pkg.sv
sv/fcd_adj_mem.sv
sv/five_clique_detector.sv
bench/five_clique_detector_tb.sv
